// ===== rtl/core/scsa_pkg.sv =====
package scsa_pkg;

    localparam int CLASS_W = 3;
    localparam int SIZE_W  = 16;
    localparam int SLOT_W  = 8;
    localparam int USED_W  = 9;
    localparam int ERR_W   = 3;

    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_TOO_LARGE = 3'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY     = 3'd2;
    localparam logic [ERR_W-1:0] ERR_ALL_FREE  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_RANGE     = 3'd4;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic load;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_blocked;
    } t_ctrl_sts;

endpackage

// ===== rtl/core/scsa_ctrl.sv =====
module scsa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  scsa_pkg::t_ctrl_sts i_sts,
    output scsa_pkg::t_ctrl_cmd o_cmd
);
    import scsa_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        o_s_tready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_sts.out_blocked) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/scsa_datapath.sv =====
module scsa_datapath #(
    parameter int SMALLEST_CLASS_SLOTS = 256,
    parameter int CLASS_COUNT          = 6
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  scsa_pkg::t_ctrl_cmd                  i_cmd,
    output scsa_pkg::t_ctrl_sts                  o_sts,
    input  logic                                 i_action,
    input  logic [scsa_pkg::SIZE_W-1:0]          i_request_size,
    input  logic [scsa_pkg::SLOT_W-1:0]          i_slot_index,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_ok,
    output logic [scsa_pkg::CLASS_W-1:0]         o_size_class,
    output logic [scsa_pkg::SLOT_W-1:0]          o_granted_slot,
    output logic [scsa_pkg::USED_W-1:0]          o_class_used,
    output logic [scsa_pkg::ERR_W-1:0]           o_error_code
);
    import scsa_pkg::*;

    localparam int DEPTH = 2 * SMALLEST_CLASS_SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(SMALLEST_CLASS_SLOTS) + 1;
    localparam int KW    = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

    function automatic logic [KW:0] pick_class(input logic [SIZE_W-1:0] sz);
        logic [KW:0] res;
        res = '0;
        for (int j = CLASS_COUNT - 1; j >= 0; j--) begin
            if (32'(sz) <= (32'd8 << j)) begin
                res = {1'b1, KW'(j)};
            end
        end
        return res;
    endfunction

    function automatic logic [AW-1:0] class_base(input logic [KW-1:0] k);
        return AW'(32'(DEPTH) - (32'(DEPTH) >> k));
    endfunction

    function automatic logic [TW-1:0] class_cap(input logic [KW-1:0] k);
        return TW'(32'(SMALLEST_CLASS_SLOTS) >> k);
    endfunction

    logic [SLOT_W-1:0] r_mem [DEPTH];
    logic [SLOT_W-1:0] r_rdata;
    logic [TW-1:0]     r_top [CLASS_COUNT];
    logic [TW-1:0]     r_low [CLASS_COUNT];

    logic              r_action;
    logic [SIZE_W-1:0] r_size;
    logic [SLOT_W-1:0] r_slot;

    logic              r_out_valid;
    logic              r_ok;
    logic [CLASS_W-1:0] r_class;
    logic [SLOT_W-1:0] r_granted;
    logic [USED_W-1:0] r_used;
    logic [ERR_W-1:0]  r_err;

    // read address from the incoming item
    logic [KW:0]   in_pick;
    logic [KW-1:0] in_k;
    logic [AW-1:0] rd_addr;

    assign in_pick = pick_class(i_request_size);
    assign in_k    = in_pick[KW-1:0];
    assign rd_addr = class_base(in_k) + AW'(r_top[in_k]) - AW'(1);

    // execution from the held item
    logic [KW:0]        ex_pick;
    logic               ex_fits;
    logic [KW-1:0]      ex_k;
    logic [TW-1:0]      ex_cap;
    logic [TW-1:0]      ex_top;
    logic [TW-1:0]      ex_low;
    logic [TW-1:0]      ex_tm1;
    logic [AW-1:0]      wr_addr;
    logic [TW-1:0]      n_top;
    logic [TW-1:0]      n_low;
    logic               n_ok;
    logic [SLOT_W-1:0]  n_granted;
    logic [ERR_W-1:0]   n_err;
    logic               do_push;

    assign ex_pick = pick_class(r_size);
    assign ex_fits = ex_pick[KW];
    assign ex_k    = ex_pick[KW-1:0];
    assign ex_cap  = class_cap(ex_k);
    assign ex_top  = r_top[ex_k];
    assign ex_low  = r_low[ex_k];
    assign ex_tm1  = ex_top - TW'(1);
    assign wr_addr = class_base(ex_k) + AW'(ex_top);

    always_comb begin
        n_top     = ex_top;
        n_low     = ex_low;
        n_ok      = 1'b0;
        n_granted = '0;
        n_err     = ERR_NONE;
        do_push   = 1'b0;
        if (!ex_fits) begin
            n_err = ERR_TOO_LARGE;
        end else if (r_action == ACT_ALLOC) begin
            if (ex_top == '0) begin
                n_err = ERR_EMPTY;
            end else begin
                n_ok  = 1'b1;
                n_top = ex_tm1;
                // entries below the low mark were never written, the slot is the stack position itself
                if (ex_top == ex_low) begin
                    n_granted = SLOT_W'(ex_tm1);
                    n_low     = ex_tm1;
                end else begin
                    n_granted = r_rdata;
                end
            end
        end else begin
            if (ex_top >= ex_cap) begin
                n_err = ERR_ALL_FREE;
            end else if (32'(r_slot) >= 32'(ex_cap)) begin
                n_err = ERR_RANGE;
            end else begin
                n_ok    = 1'b1;
                n_top   = ex_top + TW'(1);
                do_push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rdata  <= r_mem[rd_addr];
            r_action <= i_action;
            r_size   <= i_request_size;
            r_slot   <= i_slot_index;
        end
        if (i_cmd.commit && do_push) begin
            r_mem[wr_addr] <= r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < CLASS_COUNT; j++) begin
                r_top[j] <= TW'(32'(SMALLEST_CLASS_SLOTS) >> j);
                r_low[j] <= TW'(32'(SMALLEST_CLASS_SLOTS) >> j);
            end
        end else if (i_cmd.commit && ex_fits) begin
            r_top[ex_k] <= n_top;
            r_low[ex_k] <= n_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ok      <= n_ok;
            r_class   <= ex_fits ? CLASS_W'(ex_k) : '0;
            r_granted <= n_granted;
            r_used    <= ex_fits ? USED_W'(ex_cap - n_top) : '0;
            r_err     <= n_err;
        end
    end

    assign o_sts.out_blocked = r_out_valid && !i_ready;
    assign o_valid           = r_out_valid;
    assign o_ok              = r_ok;
    assign o_size_class      = r_class;
    assign o_granted_slot    = r_granted;
    assign o_class_used      = r_used;
    assign o_error_code      = r_err;

endmodule

// ===== rtl/core/size_class_slot_allocator_top.sv =====
// slot allocator with segregated size classes, one lifo free stack per class
// slave channel: one request item per handshake, tuser = action (0 alloc, 1 free),
//   tdata = request_size, slot_index
// master channel: one result item per request, tuser = ok,
//   tdata = size_class, granted_slot, class_used, error_code
// the request is loaded at accept, executed in the exec state and its result registered at
//   commit; the stack memory is read at accept, the stack top update and write back follow
//   at commit, and no new request is taken until the previous one has committed
// the result register frees the input side: a new request is taken while the
//   previous result waits; a request stays in execution while the result register
//   holds an untaken item, and s_tready stays low until it commits
// reset: synchronous active low, every class is all free, no clearing pass runs,
//   the block takes requests in the first cycle after reset
// class k holds up to 8 << k bytes and SMALLEST_CLASS_SLOTS >> k slots
module size_class_slot_allocator_top #(
    parameter int SMALLEST_CLASS_SLOTS = 256,
    parameter int CLASS_COUNT          = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // request_size, slot_index
    input  logic        i_s_tuser,   // action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // size_class, granted_slot, class_used, error_code, pad
    output logic        o_m_tuser    // ok
);
    import scsa_pkg::*;

    t_ctrl_cmd          cmd;
    t_ctrl_sts          sts;
    logic [CLASS_W-1:0] size_class;
    logic [SLOT_W-1:0]  granted_slot;
    logic [USED_W-1:0]  class_used;
    logic [ERR_W-1:0]   error_code;

    scsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    scsa_datapath #(
        .SMALLEST_CLASS_SLOTS (SMALLEST_CLASS_SLOTS),
        .CLASS_COUNT          (CLASS_COUNT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_s_tuser),
        .i_request_size (i_s_tdata[15:0]),
        .i_slot_index   (i_s_tdata[23:16]),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_ok           (o_m_tuser),
        .o_size_class   (size_class),
        .o_granted_slot (granted_slot),
        .o_class_used   (class_used),
        .o_error_code   (error_code)
    );

    assign o_m_tdata = {1'b0, error_code, class_used, granted_slot, size_class};

endmodule
